// ===== hdl/dpt_pkg.sv =====
// Shared types, constants and tables for the deterministic primality test.
// Depends on nothing; used by dpt_mulmod and deterministic_primality_test.
package dpt_pkg;

   localparam int unsigned DataWidth  = 64;
   localparam int unsigned LaneCount  = 35;
   localparam int unsigned LaneWidth  = 8;
   localparam int unsigned BaseWidth  = 21;
   localparam int unsigned RangeCount = 9;

   typedef logic [DataWidth-1:0] word_type;
   typedef logic [LaneWidth-1:0] lane_type;
   typedef logic [BaseWidth-1:0] base_type;
   typedef logic [3:0]           range_type;

   localparam word_type SmallLimit = 64'd152;
   localparam word_type TrialLimit = 64'd22801;

   // Odd trial primes 3 .. 151, one per remainder lane.
   function automatic lane_type lane_prime(input int unsigned idx);
      lane_type p;
      case (idx)
         0: p = 8'd3;     1: p = 8'd5;     2: p = 8'd7;     3: p = 8'd11;
         4: p = 8'd13;    5: p = 8'd17;    6: p = 8'd19;    7: p = 8'd23;
         8: p = 8'd29;    9: p = 8'd31;    10: p = 8'd37;   11: p = 8'd41;
         12: p = 8'd43;   13: p = 8'd47;   14: p = 8'd53;   15: p = 8'd59;
         16: p = 8'd61;   17: p = 8'd67;   18: p = 8'd71;   19: p = 8'd73;
         20: p = 8'd79;   21: p = 8'd83;   22: p = 8'd89;   23: p = 8'd97;
         24: p = 8'd101;  25: p = 8'd103;  26: p = 8'd107;  27: p = 8'd109;
         28: p = 8'd113;  29: p = 8'd127;  30: p = 8'd131;  31: p = 8'd137;
         32: p = 8'd139;  33: p = 8'd149;  34: p = 8'd151;
         default: p = 8'd3;
      endcase
      return p;
   endfunction

   // Upper bounds (exclusive) of the base-set ranges; the last range is open.
   function automatic word_type range_limit(input range_type k);
      word_type t;
      unique case (k)
         4'd0: t = 64'd1373653;
         4'd1: t = 64'd9080191;
         4'd2: t = 64'd4759123141;
         4'd3: t = 64'd1122004669633;
         4'd4: t = 64'd2152302898747;
         4'd5: t = 64'd3474749660383;
         4'd6: t = 64'd341550071728321;
         4'd7: t = 64'd3825123056546413051;
         default: t = '1;
      endcase
      return t;
   endfunction

   // Number of witnesses used in each range.
   function automatic logic [3:0] base_count(input range_type k);
      logic [3:0] c;
      unique case (k)
         4'd0: c = 4'd2;
         4'd1: c = 4'd2;
         4'd2: c = 4'd3;
         4'd3: c = 4'd4;
         4'd4: c = 4'd5;
         4'd5: c = 4'd6;
         4'd6: c = 4'd7;
         4'd7: c = 4'd9;
         default: c = 4'd12;
      endcase
      return c;
   endfunction

   // Witness number idx of range k.
   function automatic base_type base_value(input range_type k, input logic [3:0] idx);
      base_type b;
      b = '0;
      unique case (k)
         4'd0: b = (idx == 4'd0) ? 21'd2 : 21'd3;
         4'd1: b = (idx == 4'd0) ? 21'd31 : 21'd73;
         4'd2: begin
            case (idx)
               4'd0: b = 21'd2;
               4'd1: b = 21'd7;
               default: b = 21'd61;
            endcase
         end
         4'd3: begin
            case (idx)
               4'd0: b = 21'd2;
               4'd1: b = 21'd13;
               4'd2: b = 21'd23;
               default: b = 21'd1662803;
            endcase
         end
         default: begin
            case (idx)
               4'd0: b = 21'd2;   4'd1: b = 21'd3;   4'd2: b = 21'd5;
               4'd3: b = 21'd7;   4'd4: b = 21'd11;  4'd5: b = 21'd13;
               4'd6: b = 21'd17;  4'd7: b = 21'd19;  4'd8: b = 21'd23;
               4'd9: b = 21'd29;  4'd10: b = 21'd31;
               default: b = 21'd37;
            endcase
         end
      endcase
      return b;
   endfunction

   // Modular add for a, b < m: two subtracts, one compare, one add.
   function automatic word_type add_mod(input word_type a, input word_type b,
                                        input word_type m);
      word_type room;
      room = m - b;
      return (a >= room) ? (a - room) : (a + b);
   endfunction

endpackage

// ===== hdl/dpt_mulmod.sv =====
// Bit-serial modular multiplier: one doubling or one conditional add per cycle.
// Depends on dpt_pkg for the word type and the modular add.
module dpt_mulmod
   import dpt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     mul_start,
   input  word_type mul_a,
   input  word_type mul_b,
   input  word_type mul_m,
   output logic     mul_done,
   output word_type mul_result
);

   word_type   acc_ff, acc_in;
   word_type   a_ff, a_in;
   word_type   b_ff, b_in;
   word_type   m_ff, m_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       half_ff, half_in;
   logic       run_ff, run_in;
   logic       done_ff, done_in;
   word_type   addend;

   // The single adder doubles the accumulator, then adds the multiplicand.
   assign addend = half_ff ? a_ff : acc_ff;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      half_in = half_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (mul_start) begin
         acc_in  = '0;
         a_in    = mul_a;
         b_in    = mul_b;
         m_in    = mul_m;
         cnt_in  = '0;
         half_in = 1'b0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (!half_ff || b_ff[DataWidth-1]) begin
            acc_in = add_mod(acc_ff, addend, m_ff);
         end
         half_in = !half_ff;
         if (half_ff) begin
            b_in   = {b_ff[DataWidth-2:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == '1) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      m_ff    <= m_in;
      cnt_ff  <= cnt_in;
      half_ff <= half_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign mul_done   = done_ff;
   assign mul_result = acc_ff;

endmodule

// ===== hdl/deterministic_primality_test.sv =====
// Top level of the deterministic 64-bit primality test.
// Depends on dpt_pkg and dpt_mulmod.
//
//  Channel  Ports                        Transfer when
//  request  start, busy, req_candidate   start high and busy low at a clock edge
//  response rsp_strobe, rsp_is_prime     rsp_strobe high for one cycle
//
// One candidate is worked on at a time; busy stays high until its result is out.
// Trial division runs bit-serially over the candidate, then small and screened values
// finish in the decide state. Miller-Rabin work is set by the bit-serial multiplier:
// per witness about (popcount(d) + bitlength(d) + s) multiplies, up to twelve
// witnesses.
// Reset is synchronous and returns the controller to idle; results cannot be stalled.
module deterministic_primality_test
   import dpt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  word_type req_candidate,
   output logic     rsp_strobe,
   output logic     rsp_is_prime
);

   localparam logic [3:0] StIdle   = 4'd0;
   localparam logic [3:0] StTrial  = 4'd1;
   localparam logic [3:0] StDecide = 4'd2;
   localparam logic [3:0] StSplit  = 4'd3;
   localparam logic [3:0] StRange  = 4'd4;
   localparam logic [3:0] StBase   = 4'd5;
   localparam logic [3:0] StExp    = 4'd6;
   localparam logic [3:0] StExpR   = 4'd7;
   localparam logic [3:0] StExpP   = 4'd8;
   localparam logic [3:0] StSq     = 4'd9;
   localparam logic [3:0] StSqW    = 4'd10;

   logic [3:0] state_ff, state_in;
   word_type   n_ff, n_in;
   word_type   nm1_ff, nm1_in;
   word_type   sh_ff, sh_in;
   word_type   d_ff, d_in;
   word_type   e_ff, e_in;
   word_type   r_ff, r_in;
   word_type   p_ff, p_in;
   word_type   x_ff, x_in;
   logic [6:0] s_ff, s_in;
   logic [6:0] scnt_ff, scnt_in;
   logic [5:0] bcnt_ff, bcnt_in;
   range_type  range_ff, range_in;
   logic [3:0] bidx_ff, bidx_in;
   lane_type   rem_ff [LaneCount];
   lane_type   rem_in [LaneCount];
   logic       out_ff, out_in;
   logic       strobe_ff, strobe_in;

   logic       mul_start;
   word_type   mul_a, mul_b;
   logic       mul_done;
   word_type   mul_result;

   logic       any_zero;
   logic       small_div;
   logic       is_tiny_prime;
   logic [8:0] wide_rem;

   dpt_mulmod u_mulmod (
      .clock      (clock),
      .reset      (reset),
      .mul_start  (mul_start),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_m      (n_ff),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

   // Remainder lanes: each takes the next candidate bit, most significant first.
   always_comb begin
      wide_rem = '0;
      for (int i = 0; i < LaneCount; i++) begin
         wide_rem = {rem_ff[i], sh_ff[DataWidth-1]};
         if (wide_rem >= {1'b0, lane_prime(i)}) begin
            wide_rem = wide_rem - {1'b0, lane_prime(i)};
         end
         rem_in[i] = (state_ff == StTrial) ? wide_rem[LaneWidth-1:0] : rem_ff[i];
         if (state_ff == StIdle) begin
            rem_in[i] = '0;
         end
      end
   end

   // Divisibility summaries once all 64 bits have gone through.
   always_comb begin
      any_zero = 1'b0;
      for (int i = 0; i < LaneCount; i++) begin
         any_zero = any_zero | (rem_ff[i] == '0);
      end
      small_div = !n_ff[0] || (rem_ff[0] == '0) || (rem_ff[1] == '0)
                  || (rem_ff[2] == '0) || (rem_ff[3] == '0);
      is_tiny_prime = (n_ff == 64'd2) || (n_ff == 64'd3) || (n_ff == 64'd5)
                      || (n_ff == 64'd7) || (n_ff == 64'd11);
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      nm1_in    = nm1_ff;
      sh_in     = sh_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      r_in      = r_ff;
      p_in      = p_ff;
      x_in      = x_ff;
      s_in      = s_ff;
      scnt_in   = scnt_ff;
      bcnt_in   = bcnt_ff;
      range_in  = range_ff;
      bidx_in   = bidx_ff;
      out_in    = out_ff;
      strobe_in = 1'b0;
      mul_start = 1'b0;
      mul_a     = r_ff;
      mul_b     = p_ff;
      unique case (state_ff)
         StIdle: begin
            if (start) begin
               n_in     = req_candidate;
               nm1_in   = req_candidate - 64'd1;
               sh_in    = req_candidate;
               bcnt_in  = '0;
               state_in = StTrial;
            end
         end
         StTrial: begin
            sh_in   = {sh_ff[DataWidth-2:0], 1'b0};
            bcnt_in = bcnt_ff + 6'd1;
            if (bcnt_ff == '1) begin
               state_in = StDecide;
            end
         end
         StDecide: begin
            d_in     = {1'b0, n_ff[DataWidth-1:1]};
            s_in     = 7'd1;
            range_in = '0;
            state_in = StIdle;
            strobe_in = 1'b1;
            if (n_ff <= SmallLimit) begin
               out_in = (n_ff < 64'd2) || is_tiny_prime || !small_div;
            end else if (!n_ff[0] || any_zero) begin
               out_in = 1'b0;
            end else if (n_ff <= TrialLimit) begin
               out_in = 1'b1;
            end else begin
               strobe_in = 1'b0;
               state_in  = StSplit;
            end
         end
         StSplit: begin
            if (d_ff[0]) begin
               state_in = StRange;
            end else begin
               d_in = {1'b0, d_ff[DataWidth-1:1]};
               s_in = s_ff + 7'd1;
            end
         end
         StRange: begin
            if (range_ff == range_type'(RangeCount - 1) || n_ff < range_limit(range_ff)) begin
               bidx_in  = '0;
               state_in = StBase;
            end else begin
               range_in = range_ff + 4'd1;
            end
         end
         StBase: begin
            p_in     = word_type'(base_value(range_ff, bidx_ff));
            r_in     = 64'd1;
            e_in     = d_ff;
            state_in = StExp;
         end
         StExp: begin
            if (e_ff == '0) begin
               x_in     = r_ff;
               scnt_in  = s_ff;
               state_in = StSq;
            end else if (e_ff[0]) begin
               mul_start = 1'b1;
               state_in  = StExpR;
            end else begin
               mul_start = 1'b1;
               mul_a     = p_ff;
               state_in  = StExpP;
            end
         end
         StExpR: begin
            if (mul_done) begin
               r_in      = mul_result;
               mul_start = 1'b1;
               mul_a     = p_ff;
               state_in  = StExpP;
            end
         end
         StExpP: begin
            if (mul_done) begin
               p_in     = mul_result;
               e_in     = {1'b0, e_ff[DataWidth-1:1]};
               state_in = StExp;
            end
         end
         StSq: begin
            mul_start = 1'b1;
            mul_a     = x_ff;
            mul_b     = x_ff;
            state_in  = StSqW;
         end
         StSqW: begin
            mul_a = x_ff;
            mul_b = x_ff;
            if (mul_done) begin
               x_in    = mul_result;
               scnt_in = scnt_ff - 7'd1;
               if (mul_result == 64'd1 && x_ff != 64'd1 && x_ff != nm1_ff) begin
                  out_in    = 1'b0;
                  strobe_in = 1'b1;
                  state_in  = StIdle;
               end else if (scnt_ff == 7'd1) begin
                  if (mul_result != 64'd1) begin
                     out_in    = 1'b0;
                     strobe_in = 1'b1;
                     state_in  = StIdle;
                  end else if (bidx_ff == base_count(range_ff) - 4'd1) begin
                     out_in    = 1'b1;
                     strobe_in = 1'b1;
                     state_in  = StIdle;
                  end else begin
                     bidx_in  = bidx_ff + 4'd1;
                     state_in = StBase;
                  end
               end else begin
                  state_in = StSq;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      nm1_ff   <= nm1_in;
      sh_ff    <= sh_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      r_ff     <= r_in;
      p_ff     <= p_in;
      x_ff     <= x_in;
      s_ff     <= s_in;
      scnt_ff  <= scnt_in;
      bcnt_ff  <= bcnt_in;
      range_ff <= range_in;
      bidx_ff  <= bidx_in;
      out_ff   <= out_in;
      rem_ff   <= rem_in;
      if (reset) begin
         state_ff  <= StIdle;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy         = (state_ff != StIdle);
   assign rsp_strobe   = strobe_ff;
   assign rsp_is_prime = out_ff;

endmodule
